/* rtl/skf_pkg.sv */
package skf_pkg;

  localparam int IDX_W          = 6;
  localparam int ROT_W          = 16;
  localparam int POS_W          = 20;
  localparam int FRAC           = 14;
  localparam int T_W            = 24;
  localparam int DIGIT_W        = 4;
  localparam int PROD_W         = T_W + ROT_W;
  localparam int SUM_W          = PROD_W + 4;
  localparam int RND_W          = SUM_W - FRAC;
  localparam int EXT_W          = 9;
  localparam int MAX_JOINTS_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ISSUE,
    ST_MUL,
    ST_ROUND,
    ST_FINISH
  } state_t;

  // R: parent * local rotation, T: parent * position, S: t * conj(parent).
  typedef enum logic [1:0] {
    PH_R,
    PH_T,
    PH_S
  } phase_t;

  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
  } term_t;

  // One term of the Hamilton product a * b: component c, term k.
  function automatic term_t skf_term(input logic [1:0] c, input logic [1:0] k);
    term_t t;
    case ({c, k})
      4'h0: t = '{2'd0, 2'd3, 1'b0};
      4'h1: t = '{2'd3, 2'd0, 1'b0};
      4'h2: t = '{2'd1, 2'd2, 1'b0};
      4'h3: t = '{2'd2, 2'd1, 1'b1};
      4'h4: t = '{2'd1, 2'd3, 1'b0};
      4'h5: t = '{2'd3, 2'd1, 1'b0};
      4'h6: t = '{2'd2, 2'd0, 1'b0};
      4'h7: t = '{2'd0, 2'd2, 1'b1};
      4'h8: t = '{2'd2, 2'd3, 1'b0};
      4'h9: t = '{2'd3, 2'd2, 1'b0};
      4'ha: t = '{2'd0, 2'd1, 1'b0};
      4'hb: t = '{2'd1, 2'd0, 1'b1};
      4'hc: t = '{2'd3, 2'd3, 1'b0};
      4'hd: t = '{2'd0, 2'd0, 1'b1};
      4'he: t = '{2'd1, 2'd1, 1'b1};
      4'hf: t = '{2'd2, 2'd2, 1'b1};
      default: t = '{2'd0, 2'd0, 1'b0};
    endcase
    return t;
  endfunction

endpackage

/* rtl/skf_ram.sv */
module skf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/skf_dmul.sv */
module skf_dmul import skf_pkg::*; #(
  parameter int A_W = T_W,
  parameter int B_W = ROT_W,
  parameter int D_W = DIGIT_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic                    done,
  output logic signed [A_W+B_W-1:0] prod
);

  localparam int NDIG = B_W / D_W;
  localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int P_W  = A_W + B_W;

  logic signed [A_W-1:0]     a_reg;
  logic [B_W-1:0]            b_sh;
  logic signed [P_W-1:0]     acc;
  logic [CW-1:0]             cnt;
  logic                      busy;
  logic signed [D_W:0]       dext;
  logic signed [A_W+D_W:0]   pp;

  // The multiplier digits leave the shift register most significant first;
  // only the top digit carries the sign.
  always_comb begin
    if (cnt == '0) begin
      dext = $signed({b_sh[B_W-1], b_sh[B_W-1 -: D_W]});
    end else begin
      dext = $signed({1'b0, b_sh[B_W-1 -: D_W]});
    end
    pp = a_reg * dext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(NDIG - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_reg <= a;
      b_sh  <= b;
      acc   <= '0;
    end else if (busy) begin
      b_sh <= b_sh << D_W;
      acc  <= (acc <<< D_W) + P_W'(pp);
    end
  end

  assign done = !busy;
  assign prod = acc;

endmodule

/* rtl/skeleton_forward_kinematics.sv */
// Channel  | Handshake                | Payload
// joint    | joint_valid, joint_stall | joint_index, parent_index, local_rot_*, local_pos_*
// pose     | pose_valid, pose_stall   | out_joint_index, global_rot_*, global_pos_*, flags
//
// A root joint or a joint with a bad parent goes from accept straight through the
// parent read to hand-over. Any other joint also needs 44 products on one shared
// multiplier that consumes a 4-bit digit per cycle, each started by an issue step,
// plus 11 rounding steps, between the parent read and the hand-over.
// Reset is synchronous; the pose tables are not cleared.
// The result sits in an output register, so a stalled pose channel only holds
// the block once the next joint is finished.
module skeleton_forward_kinematics import skf_pkg::*; #(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    joint_valid,
  output logic                    joint_stall,
  input  logic [IDX_W-1:0]        joint_index,
  input  logic [IDX_W-1:0]        parent_index,
  input  logic signed [ROT_W-1:0] local_rot_x,
  input  logic signed [ROT_W-1:0] local_rot_y,
  input  logic signed [ROT_W-1:0] local_rot_z,
  input  logic signed [ROT_W-1:0] local_rot_w,
  input  logic signed [POS_W-1:0] local_pos_x,
  input  logic signed [POS_W-1:0] local_pos_y,
  input  logic signed [POS_W-1:0] local_pos_z,
  output logic                    pose_valid,
  input  logic                    pose_stall,
  output logic [IDX_W-1:0]        out_joint_index,
  output logic signed [ROT_W-1:0] global_rot_x,
  output logic signed [ROT_W-1:0] global_rot_y,
  output logic signed [ROT_W-1:0] global_rot_z,
  output logic signed [ROT_W-1:0] global_rot_w,
  output logic signed [POS_W-1:0] global_pos_x,
  output logic signed [POS_W-1:0] global_pos_y,
  output logic signed [POS_W-1:0] global_pos_z,
  output logic                    parent_error,
  output logic                    saturated
);

  localparam int AW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int RW_W  = 4 * ROT_W;
  localparam int PW_W  = 3 * POS_W;
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC - 1);

  state_t state, state_next;
  phase_t phase;
  logic [1:0] c, k;

  logic [IDX_W-1:0]        j_idx, p_idx;
  logic signed [ROT_W-1:0] lrot [4];
  logic signed [POS_W-1:0] lpos [3];
  logic signed [ROT_W-1:0] par_rot [4];
  logic signed [POS_W-1:0] par_pos [3];
  logic signed [T_W-1:0]   t_reg [4];
  logic signed [ROT_W-1:0] g_rot [4];
  logic signed [POS_W-1:0] g_pos [3];
  logic                    err, sat;
  logic signed [SUM_W-1:0] sum;
  logic                    out_full;

  logic                    accept, take, store;
  logic                    parent_ok, joint_ok;
  logic [EXT_W-1:0]        j_ext, p_ext, pin_ext;
  logic [RW_W-1:0]         rot_rd, rot_wr;
  logic [PW_W-1:0]         pos_rd, pos_wr;

  term_t                   term;
  logic                    mul_load, mul_done, neg;
  logic signed [T_W-1:0]   mul_a;
  logic signed [ROT_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [SUM_W-1:0] sum_rnd;
  logic signed [RND_W-1:0] rnd;
  logic signed [RND_W:0]   psum;
  logic signed [ROT_W-1:0] rot_clip;
  logic signed [POS_W-1:0] pos_clip;
  logic                    rot_ovf, pos_ovf;

  assign accept  = joint_valid && !joint_stall;
  assign take    = !out_full || !pose_stall;
  assign j_ext   = EXT_W'(j_idx);
  assign p_ext   = EXT_W'(p_idx);
  assign pin_ext = EXT_W'(parent_index);
  assign parent_ok = p_ext < EXT_W'(MAX_JOINTS);
  assign joint_ok  = j_ext < EXT_W'(MAX_JOINTS);
  assign store   = (state == ST_FINISH) && take && !err && joint_ok;

  assign rot_wr = {g_rot[3], g_rot[2], g_rot[1], g_rot[0]};
  assign pos_wr = {g_pos[2], g_pos[1], g_pos[0]};

  skf_ram #(.WIDTH(RW_W), .DEPTH(MAX_JOINTS)) u_rot_ram (
    .clk   (clk),
    .we    (store),
    .waddr (j_ext[AW-1:0]),
    .wdata (rot_wr),
    .raddr (pin_ext[AW-1:0]),
    .rdata (rot_rd)
  );

  skf_ram #(.WIDTH(PW_W), .DEPTH(MAX_JOINTS)) u_pos_ram (
    .clk   (clk),
    .we    (store),
    .waddr (j_ext[AW-1:0]),
    .wdata (pos_wr),
    .raddr (pin_ext[AW-1:0]),
    .rdata (pos_rd)
  );

  // Operand selection. The serial operand is always a parent rotation
  // component; the conjugate's sign is folded into the term sign.
  always_comb begin
    term = skf_term(c, k);
    if (phase == PH_S) begin
      mul_b = par_rot[term.ib];
      mul_a = t_reg[term.ia];
      neg   = term.neg ^ (term.ib != 2'd3);
    end else begin
      mul_b = par_rot[term.ia];
      neg   = term.neg;
      if (phase == PH_R) begin
        mul_a = T_W'(lrot[term.ib]);
      end else if (term.ib == 2'd3) begin
        mul_a = '0;
      end else begin
        mul_a = T_W'(lpos[term.ib]);
      end
    end
  end

  skf_dmul #(.A_W(T_W), .B_W(ROT_W), .D_W(DIGIT_W)) u_dmul (
    .clk  (clk),
    .rst  (rst),
    .load (mul_load),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (prod)
  );

  // Round half up to 14 fraction bits, then saturate; positions add the parent position first.
  always_comb begin
    sum_rnd  = sum + HALF;
    rnd      = $signed(sum_rnd[SUM_W-1:FRAC]);
    psum     = (RND_W + 1)'(rnd) + (RND_W + 1)'(par_pos[c]);
    rot_ovf  = !((&rnd[RND_W-1:ROT_W-1]) || !(|rnd[RND_W-1:ROT_W-1]));
    pos_ovf  = !((&psum[RND_W:POS_W-1]) || !(|psum[RND_W:POS_W-1]));
    if (rot_ovf) begin
      rot_clip = rnd[RND_W-1] ? {1'b1, {(ROT_W-1){1'b0}}} : {1'b0, {(ROT_W-1){1'b1}}};
    end else begin
      rot_clip = rnd[ROT_W-1:0];
    end
    if (pos_ovf) begin
      pos_clip = psum[RND_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      pos_clip = psum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_load    = 1'b0;
    joint_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (j_idx == '0 || p_idx >= j_idx) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        mul_load   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = (k == 2'd3) ? ST_ROUND : ST_ISSUE;
        end
      end
      ST_ROUND: begin
        if (phase == PH_S && c == 2'd2) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_ISSUE;
        end
      end
      ST_FINISH: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          j_idx   <= joint_index;
          p_idx   <= parent_index;
          lrot[0] <= local_rot_x;
          lrot[1] <= local_rot_y;
          lrot[2] <= local_rot_z;
          lrot[3] <= local_rot_w;
          lpos[0] <= local_pos_x;
          lpos[1] <= local_pos_y;
          lpos[2] <= local_pos_z;
        end
      end
      ST_LOAD: begin
        sat   <= 1'b0;
        sum   <= '0;
        phase <= PH_R;
        c     <= 2'd0;
        k     <= 2'd0;
        for (int i = 0; i < 4; i++) begin
          par_rot[i] <= parent_ok ? rot_rd[i*ROT_W +: ROT_W] : '0;
        end
        for (int i = 0; i < 3; i++) begin
          par_pos[i] <= parent_ok ? pos_rd[i*POS_W +: POS_W] : '0;
        end
        if (j_idx == '0) begin
          err <= 1'b0;
          for (int i = 0; i < 4; i++) begin
            g_rot[i] <= lrot[i];
          end
          for (int i = 0; i < 3; i++) begin
            g_pos[i] <= lpos[i];
          end
        end else if (p_idx >= j_idx) begin
          err <= 1'b1;
          for (int i = 0; i < 4; i++) begin
            g_rot[i] <= '0;
          end
          for (int i = 0; i < 3; i++) begin
            g_pos[i] <= '0;
          end
        end else begin
          err <= 1'b0;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          sum <= neg ? sum - SUM_W'(prod) : sum + SUM_W'(prod);
          k   <= k + 2'd1;
        end
      end
      ST_ROUND: begin
        sum <= '0;
        case (phase)
          PH_R: begin
            g_rot[c] <= rot_clip;
            sat      <= sat | rot_ovf;
          end
          PH_T: begin
            t_reg[c] <= rnd[T_W-1:0];
          end
          PH_S: begin
            g_pos[c] <= pos_clip;
            sat      <= sat | pos_ovf;
          end
          default: ;
        endcase
        if (c == 2'd3) begin
          c     <= 2'd0;
          phase <= (phase == PH_R) ? PH_T : PH_S;
        end else begin
          c <= c + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (state == ST_FINISH && take) begin
      out_full <= 1'b1;
    end else if (!pose_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && take) begin
      out_joint_index <= j_idx;
      global_rot_x    <= g_rot[0];
      global_rot_y    <= g_rot[1];
      global_rot_z    <= g_rot[2];
      global_rot_w    <= g_rot[3];
      global_pos_x    <= g_pos[0];
      global_pos_y    <= g_pos[1];
      global_pos_z    <= g_pos[2];
      parent_error    <= err;
      saturated       <= sat & !err;
    end
  end

  assign pose_valid = out_full;

endmodule

/* verif/skf_checker.sv */
`timescale 1ns / 100ps

module skf_checker import skf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    joint_valid,
  input  logic                    joint_stall,
  input  logic [IDX_W-1:0]        joint_index,
  input  logic [IDX_W-1:0]        parent_index,
  input  logic signed [ROT_W-1:0] local_rot_x,
  input  logic signed [ROT_W-1:0] local_rot_y,
  input  logic signed [ROT_W-1:0] local_rot_z,
  input  logic signed [ROT_W-1:0] local_rot_w,
  input  logic signed [POS_W-1:0] local_pos_x,
  input  logic signed [POS_W-1:0] local_pos_y,
  input  logic signed [POS_W-1:0] local_pos_z,
  input  logic                    pose_valid,
  input  logic                    pose_stall,
  input  logic [IDX_W-1:0]        out_joint_index,
  input  logic signed [ROT_W-1:0] global_rot_x,
  input  logic signed [ROT_W-1:0] global_rot_y,
  input  logic signed [ROT_W-1:0] global_rot_z,
  input  logic signed [ROT_W-1:0] global_rot_w,
  input  logic signed [POS_W-1:0] global_pos_x,
  input  logic signed [POS_W-1:0] global_pos_y,
  input  logic signed [POS_W-1:0] global_pos_z,
  input  logic                    parent_error,
  input  logic                    saturated,
  output int                      errors,
  output int                      outstanding,
  output int                      sat_poses
);

  typedef longint quat_t [4];

  typedef struct packed {
    logic [IDX_W-1:0]            idx;
    logic [3:0][ROT_W-1:0]       rot;
    logic [2:0][POS_W-1:0]       pos;
    logic                        err;
    logic                        sat;
  } pose_rec_t;

  longint    rot_table [MAX_JOINTS_DEF][4];
  longint    pos_table [MAX_JOINTS_DEF][3];
  pose_rec_t poses_due [$];

  initial begin
    errors = 0;
    outstanding = 0;
    sat_poses = 0;
  end

  // Round half up to 14 fraction bits; arithmetic shift floors.
  function automatic longint round_q14(input longint v);
    return (v + 64'sd8192) >>> FRAC;
  endfunction

  function automatic longint clamp(input longint v, input int w, inout bit sat);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void hamilton(input quat_t a, input quat_t b, output quat_t r);
    r[0] = a[0] * b[3] + a[3] * b[0] + a[1] * b[2] - a[2] * b[1];
    r[1] = a[1] * b[3] + a[3] * b[1] + a[2] * b[0] - a[0] * b[2];
    r[2] = a[2] * b[3] + a[3] * b[2] + a[0] * b[1] - a[1] * b[0];
    r[3] = a[3] * b[3] - a[0] * b[0] - a[1] * b[1] - a[2] * b[2];
  endfunction

  // Computes the expected pose of the joint on the input port and, unless its parent is bad, updates the tables.
  function automatic pose_rec_t solve_joint();
    pose_rec_t e;
    quat_t     lr, pr, cq, pq, prod, t, r;
    longint    lp [3];
    bit        sat;
    int        j, p;
    e = '0;
    sat = 1'b0;
    j = joint_index;
    p = parent_index;
    lr = '{longint'(local_rot_x), longint'(local_rot_y),
           longint'(local_rot_z), longint'(local_rot_w)};
    lp = '{longint'(local_pos_x), longint'(local_pos_y), longint'(local_pos_z)};
    e.idx = joint_index;
    if (j == 0) begin
      for (int i = 0; i < 4; i++) begin
        e.rot[i] = lr[i][ROT_W-1:0];
        rot_table[0][i] = lr[i];
      end
      for (int i = 0; i < 3; i++) begin
        e.pos[i] = lp[i][POS_W-1:0];
        pos_table[0][i] = lp[i];
      end
    end else if (p >= j) begin
      e.err = 1'b1;
    end else begin
      for (int i = 0; i < 4; i++) pr[i] = rot_table[p][i];
      hamilton(pr, lr, prod);
      for (int i = 0; i < 4; i++) prod[i] = clamp(round_q14(prod[i]), ROT_W, sat);
      pq = '{lp[0], lp[1], lp[2], 64'sd0};
      hamilton(pr, pq, t);
      for (int i = 0; i < 4; i++) t[i] = round_q14(t[i]);
      cq = '{-pr[0], -pr[1], -pr[2], pr[3]};
      hamilton(t, cq, r);
      for (int i = 0; i < 3; i++)
        r[i] = clamp(round_q14(r[i]) + pos_table[p][i], POS_W, sat);
      for (int i = 0; i < 4; i++) begin
        e.rot[i] = prod[i][ROT_W-1:0];
        rot_table[j][i] = prod[i];
      end
      for (int i = 0; i < 3; i++) begin
        e.pos[i] = r[i][POS_W-1:0];
        pos_table[j][i] = r[i];
      end
      e.sat = sat;
    end
    return e;
  endfunction

  task automatic report(input string field, input longint got, input longint want,
                        input int idx);
    $display("mismatch on joint %0d, %s: got %0d, expected %0d", idx, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pose_rec_t e;
    if (!rst) begin
      if (joint_valid && !joint_stall) poses_due.insert(poses_due.size(), solve_joint());
      if (pose_valid && !pose_stall) begin
        if (poses_due.size() == 0) begin
          report("unexpected transaction", out_joint_index, 0, out_joint_index);
        end else begin
          e = poses_due.pop_front();
          if (saturated) sat_poses++;
          if (out_joint_index != e.idx) report("joint index", out_joint_index, e.idx, e.idx);
          if (global_rot_x != $signed(e.rot[0])) report("rot x", global_rot_x, $signed(e.rot[0]), e.idx);
          if (global_rot_y != $signed(e.rot[1])) report("rot y", global_rot_y, $signed(e.rot[1]), e.idx);
          if (global_rot_z != $signed(e.rot[2])) report("rot z", global_rot_z, $signed(e.rot[2]), e.idx);
          if (global_rot_w != $signed(e.rot[3])) report("rot w", global_rot_w, $signed(e.rot[3]), e.idx);
          if (global_pos_x != $signed(e.pos[0])) report("pos x", global_pos_x, $signed(e.pos[0]), e.idx);
          if (global_pos_y != $signed(e.pos[1])) report("pos y", global_pos_y, $signed(e.pos[1]), e.idx);
          if (global_pos_z != $signed(e.pos[2])) report("pos z", global_pos_z, $signed(e.pos[2]), e.idx);
          if (parent_error != e.err) report("parent error", parent_error, e.err, e.idx);
          if (saturated != e.sat) report("saturated", saturated, e.sat, e.idx);
        end
      end
      outstanding = poses_due.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb import skf_pkg::*;;

  localparam int NUM_ITEMS   = 1050;
  localparam int QUIET_FROM  = 950;
  localparam int CYCLE_LIMIT = 2000000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    joint_valid = 1'b0;
  logic                    joint_stall;
  logic [IDX_W-1:0]        joint_index = '0;
  logic [IDX_W-1:0]        parent_index = '0;
  logic signed [ROT_W-1:0] local_rot_x = '0;
  logic signed [ROT_W-1:0] local_rot_y = '0;
  logic signed [ROT_W-1:0] local_rot_z = '0;
  logic signed [ROT_W-1:0] local_rot_w = '0;
  logic signed [POS_W-1:0] local_pos_x = '0;
  logic signed [POS_W-1:0] local_pos_y = '0;
  logic signed [POS_W-1:0] local_pos_z = '0;
  logic                    pose_valid;
  logic                    pose_stall = 1'b0;
  logic [IDX_W-1:0]        out_joint_index;
  logic signed [ROT_W-1:0] global_rot_x, global_rot_y, global_rot_z, global_rot_w;
  logic signed [POS_W-1:0] global_pos_x, global_pos_y, global_pos_z;
  logic                    parent_error;
  logic                    saturated;

  int         errors, outstanding, sat_poses;
  int         sent = 0;
  int         bad_parents = 0;
  int         stall_left = 0;
  bit         quiet = 1'b0;
  longint     cycles = 0;
  logic [63:0] written = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  skeleton_forward_kinematics u_dut (.*);

  skf_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d poses still due", cycles, outstanding);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Pose side back-pressure: bursts of random length, each stalled with a one in three chance.
  always @(posedge clk) begin
    if (quiet || rst) begin
      pose_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pose_stall <= ($urandom_range(2, 0) == 0);
      stall_left <= $urandom_range(11, 0);
    end
  end

  function automatic logic [ROT_W-1:0] rand_rot();
    case ($urandom_range(3, 0))
      0:       return ROT_W'($urandom);
      1:       return ROT_W'($signed($urandom_range(16384, 0)) - 8192);
      default: return ROT_W'($signed($urandom_range(23170, 0)) - 11585);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    if ($urandom_range(3, 0) == 0) return POS_W'($urandom);
    return POS_W'($signed($urandom_range(65536, 0)) - 32768);
  endfunction

  // Presents one joint transaction and waits until it is accepted.
  task automatic send_joint(input int j, input int p,
                            input logic [ROT_W-1:0] rx, ry, rz, rw,
                            input logic [POS_W-1:0] px, py, pz);
    joint_valid  <= 1'b1;
    joint_index  <= IDX_W'(j);
    parent_index <= IDX_W'(p);
    local_rot_x  <= rx;
    local_rot_y  <= ry;
    local_rot_z  <= rz;
    local_rot_w  <= rw;
    local_pos_x  <= px;
    local_pos_y  <= py;
    local_pos_z  <= pz;
    do @(posedge clk); while (joint_stall);
    sent++;
    if (j == 0 || p < j) written[j] = 1'b1;
    else bad_parents++;
    if (sent >= QUIET_FROM) quiet = 1'b1;
    if (!quiet && $urandom_range(2, 0) == 0) begin
      joint_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  // A joint with random content whose parent is a lower joint already posed.
  task automatic send_random_child(input int j);
    int p;
    p = $urandom_range(j - 1, 0);
    while (!written[p]) p--;
    send_joint(j, p, rand_rot(), rand_rot(), rand_rot(), rand_rot(),
               rand_pos(), rand_pos(), rand_pos());
  endtask

  initial begin
    int j, n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: root extremes, identity, saturating parents, bad parents.
    send_joint(0, 63, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
               20'sh80000, 20'sh80000, 20'sh80000);
    send_joint(1, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
    send_joint(2, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
               20'sh80000, 20'sh7ffff, 20'sh00001);
    send_joint(0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               20'sh7ffff, 20'sh7ffff, 20'sh7ffff);
    send_joint(3, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
               20'sh80000, 20'sh80000, 20'sh80000);
    send_joint(0, 21, '0, '0, '0, 16'sh4000, '0, '0, '0);
    send_joint(4, 0, '0, '0, '0, 16'sh4000, 20'sh04000, 20'shfc000, 20'sh00000);
    send_joint(5, 4, '0, '0, 16'sh2d41, 16'sh2d41, 20'sh04000, 20'sh02000, 20'sh7ffff);
    send_joint(6, 5, 16'sh2000, 16'shE000, 16'sh2000, 16'sh2000,
               20'sh00001, 20'shfffff, 20'sh12345);
    send_joint(63, 6, 16'sh5555, 16'shAAAA, 16'sh0001, 16'shFFFF,
               20'sh55555, 20'shAAAAA, 20'sh00000);
    send_joint(7, 7, 16'sh1234, '0, '0, '0, 20'sh1, '0, '0);
    send_joint(1, 63, '0, '0, '0, 16'sh4000, '0, '0, '0);
    send_joint(62, 63, '0, '0, '0, 16'sh4000, '0, '0, '0);
    send_joint(7, 63, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
               20'sh7ffff, 20'sh7ffff, 20'sh7ffff);

    // Random skeletons: a root, then joints in order with a few broken parents.
    while (sent < NUM_ITEMS) begin
      send_joint(0, $urandom_range(63, 0), rand_rot(), rand_rot(), rand_rot(),
                 rand_rot(), rand_pos(), rand_pos(), rand_pos());
      n = ($urandom_range(7, 0) == 0) ? 63 : $urandom_range(20, 2);
      for (j = 1; j <= n && sent < NUM_ITEMS; j++) begin
        if ($urandom_range(15, 0) == 0)
          send_joint(j, $urandom_range(63, j), rand_rot(), rand_rot(), rand_rot(),
                     rand_rot(), rand_pos(), rand_pos(), rand_pos());
        else
          send_random_child(j);
      end
    end
    joint_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("%0d joint transactions sent, %0d with a bad parent.", sent, bad_parents);
    $display("%0d poses came back saturated; %0d mismatches.", sat_poses, errors);
    if (errors == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/skf_pkg.sv
rtl/skf_ram.sv
rtl/skf_dmul.sv
rtl/skeleton_forward_kinematics.sv
verif/skf_checker.sv
verif/tb.sv
